>>> rtl/merge_sort_engine_assert.svh
// Assertion macros shared by the merge sort engine modules.
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

`ifndef SYNTH

`define MSORT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: always");

`define MSORT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");

`define MSORT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");

`else

`define MSORT_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define MSORT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MSORT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/msort_pkg.sv
// Package with shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned MAX_ITEMS_DEF = 64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // accepted input word
    logic run_setup;   // compute bounds of the next run pair
    logic merge_step;  // write one merged word
    logic pass_end;    // swap banks, double run width
    logic out_read;    // read one sorted word for output
    logic clear;       // drop count and overflow flag
  } msort_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic width_ge_n;  // list is a single run
    logic run_last;    // this merge step finishes the run pair
    logic pass_last;   // the current run pair ends the list
    logic out_last;    // this read is the final sorted word
  } msort_stat_t;

endpackage

`default_nettype wire

>>> rtl/msort_datapath.sv
// Datapath: ping-pong storage banks, merge pointers and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "merge_sort_engine_assert.svh"

module msort_datapath
  import msort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire msort_cmd_t               cmd,
  output msort_stat_t                   stat,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_last_out,
  output logic                          out_overflow
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned SW = CW + 2;

  logic signed [DATA_W-1:0] bank0 [MAX_ITEMS];
  logic signed [DATA_W-1:0] bank1 [MAX_ITEMS];

  logic signed [DATA_W-1:0] rd0a_r, rd0b_r, rd1a_r, rd1b_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [WW-1:0] width_r;
  logic          sel_r;
  logic [CW-1:0] k_r, i_r, j_r, mid_r, hi_r;
  logic          out_valid_r, out_last_r, out_ovf_r;

  logic signed [DATA_W-1:0] src_a, src_b, pick;
  logic                     take_left;
  logic [CW-1:0]            k_inc, mid_calc, hi_calc;
  logic [SW-1:0]            lo_plus_w, lo_plus_2w, n_ext;
  logic [AW-1:0]            addr_a, addr_b;
  logic                     has_room;
  logic                     we0, we1;
  logic [AW-1:0]            wa0;
  logic signed [DATA_W-1:0] wd0;

  assign has_room = count_r < CW'(MAX_ITEMS);

  // Read data comes from the bank that holds the current runs
  assign src_a = sel_r ? rd1a_r : rd0a_r;
  assign src_b = sel_r ? rd1b_r : rd0b_r;

  // Take the left head unless it is exhausted, or the right head is live and not larger
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || (src_a < src_b));
  assign pick      = take_left ? src_a : src_b;

  assign k_inc      = k_r + CW'(1);
  assign n_ext      = SW'(count_r);
  assign lo_plus_w  = SW'(k_r) + SW'(width_r);
  assign lo_plus_2w = SW'(k_r) + (SW'(width_r) << 1);
  assign mid_calc   = (lo_plus_w > n_ext) ? count_r : lo_plus_w[CW-1:0];
  assign hi_calc    = (lo_plus_2w > n_ext) ? count_r : lo_plus_2w[CW-1:0];

  assign addr_a = cmd.out_read ? k_r[AW-1:0] : i_r[AW-1:0];
  assign addr_b = j_r[AW-1:0];

  // Bank 0 takes loads and merges out of bank 1; bank 1 merges out of bank 0
  assign we0 = (cmd.load && has_room) || (cmd.merge_step && sel_r);
  assign wa0 = cmd.load ? count_r[AW-1:0] : k_r[AW-1:0];
  assign wd0 = cmd.load ? in_value : pick;
  assign we1 = cmd.merge_step && !sel_r;

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0[wa0] <= wd0;
    end
    rd0a_r <= bank0[addr_a];
    rd0b_r <= bank0[addr_b];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      bank1[k_r[AW-1:0]] <= pick;
    end
    rd1a_r <= bank1[addr_a];
    rd1b_r <= bank1[addr_b];
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (cmd.clear) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end else if (cmd.load) begin
      if (has_room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= cmd.out_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      width_r <= WW'(1);
      k_r     <= '0;
      sel_r   <= 1'b0;
    end else if (cmd.run_setup) begin
      mid_r <= mid_calc;
      hi_r  <= hi_calc;
      i_r   <= k_r;
      j_r   <= mid_calc;
    end else if (cmd.merge_step) begin
      k_r <= k_inc;
      if (take_left) begin
        i_r <= i_r + CW'(1);
      end else begin
        j_r <= j_r + CW'(1);
      end
    end else if (cmd.pass_end) begin
      sel_r   <= ~sel_r;
      width_r <= width_r << 1;
      k_r     <= '0;
    end else if (cmd.out_read) begin
      k_r <= k_inc;
    end
    out_last_r <= stat.out_last;
    out_ovf_r  <= dropped_r;
  end

  assign stat.width_ge_n = WW'(count_r) <= width_r;
  assign stat.run_last   = k_inc == hi_r;
  assign stat.pass_last  = hi_r == count_r;
  assign stat.out_last   = k_inc == count_r;

  assign out_valid        = out_valid_r;
  assign out_sorted_value = src_a;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  `MSORT_ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_r <= CW'(MAX_ITEMS))
  `MSORT_ASSERT_IMPLIES(a_merge_in_run, clk, rst_n, cmd.merge_step, k_r < hi_r)
  `MSORT_ASSERT_IMPLIES(a_merge_ptrs, clk, rst_n, cmd.merge_step,
                        (SW'(k_r) + SW'(mid_r)) == (SW'(i_r) + SW'(j_r)))

endmodule

`default_nettype wire

>>> rtl/msort_ctrl.sv
// Controller: sequences loading, merge passes and output of the sorted list.
`timescale 1ns / 1ps
`default_nettype none
`include "merge_sort_engine_assert.svh"

module msort_ctrl
  import msort_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        in_last_in,
  input  wire msort_stat_t stat,
  output msort_cmd_t       cmd,
  output logic             busy
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_SETUP = 7'b0000100,
    ST_MREAD = 7'b0001000,
    ST_MSTEP = 7'b0010000,
    ST_PASS  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } msort_state_t;

  msort_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start && in_last_in) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.width_ge_n ? ST_OUT : ST_SETUP;
      end
      ST_SETUP: begin
        cmd.run_setup = 1'b1;
        state_nxt     = ST_MREAD;
      end
      ST_MREAD: begin
        state_nxt = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd.merge_step = 1'b1;
        if (!stat.run_last) begin
          state_nxt = ST_MREAD;
        end else if (stat.pass_last) begin
          state_nxt = ST_PASS;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_PASS: begin
        cmd.pass_end = 1'b1;
        state_nxt    = ST_CHECK;
      end
      ST_OUT: begin
        cmd.out_read = 1'b1;
        if (stat.out_last) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

  `MSORT_ASSERT_NEXT(a_last_starts_sort, clk, rst_n, start && !busy && in_last_in,
                     state_r == ST_CHECK)
  `MSORT_ASSERT_IMPLIES(a_step_after_read, clk, rst_n, state_r == ST_MSTEP,
                        $past(state_r) == ST_MREAD)
  `MSORT_ASSERT_NEXT(a_out_ends, clk, rst_n, state_r == ST_OUT && stat.out_last,
                     state_r == ST_IDLE)

endmodule

`default_nettype wire

>>> rtl/merge_sort_engine.sv
// Top level of the merge sort engine: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Collects signed 32-bit words, one per cycle while busy is low, until a word
// with in_last_in set; up to MAX_ITEMS words are kept and later ones are
// dropped, which raises out_overflow on every result of that list. The list
// is then sorted bottom-up between two ping-pong memories: ceil(log2 N)
// passes, each setting up every run pair and, per word, reading both run
// heads and then comparing and writing, then swapping banks; a check that
// the list is a single run precedes each pass and the output. The sorted
// words then leave one per cycle on out_sorted_value, marked by a one-cycle
// out_valid strobe, with out_last_out on the final word. The receiver cannot
// stall: each result is present for exactly one cycle. busy stays high from
// the cycle after the last word until the final read is issued.

module merge_sort_engine
  import msort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     in_last_in,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_last_out,
  output logic                          out_overflow
);

  msort_cmd_t  cmd;
  msort_stat_t stat;

  msort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_last_in (in_last_in),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  msort_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for merge_sort_engine: random lists in, sorted words checked.
`timescale 1ns / 1ps

module testbench;
  import msort_pkg::*;

  localparam int unsigned CAPACITY = MAX_ITEMS_DEF;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_word_t;

  // Collects words like the engine does and queues the sorted words each list yields.
  class sort_checker;
    logic signed [DATA_W-1:0] held[$];
    bit                       dropped;
    sorted_word_t             due[$];
    int unsigned              faults;

    function int unsigned pending();
      return due.size();
    endfunction

    function void take_word(logic signed [DATA_W-1:0] v, logic last);
      logic signed [DATA_W-1:0] run[$];
      logic signed [DATA_W-1:0] key;
      sorted_word_t             w;
      int                       j;
      if (held.size() < CAPACITY) held.push_back(v);
      else dropped = 1'b1;
      if (!last) return;
      run = held;
      for (int i = 1; i < run.size(); i++) begin
        key = run[i];
        j = i - 1;
        while (j >= 0 && run[j] > key) begin
          run[j+1] = run[j];
          j--;
        end
        run[j+1] = key;
      end
      foreach (run[k]) begin
        w.value = run[k];
        w.last  = (k == run.size() - 1);
        w.ovf   = dropped;
        due.push_back(w);
      end
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_word(logic signed [DATA_W-1:0] v, logic last, logic ovf);
      sorted_word_t w;
      if (due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t sort error: word %0d last=%b ovf=%b with nothing expected",
                   $realtime, v, last, ovf);
        return;
      end
      w = due.pop_front();
      if (w.value !== v || w.last !== last || w.ovf !== ovf) begin
        faults++;
        if (faults <= 10)
          $display("%0t sort error: expected %0d last=%b ovf=%b, got %0d last=%b ovf=%b",
                   $realtime, w.value, w.last, w.ovf, v, last, ovf);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last_in;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_last_out;
  logic                     out_overflow;

  sort_checker sorter;
  bit          burst;
  int unsigned words_sent;

  merge_sort_engine #(.MAX_ITEMS(CAPACITY)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last_in      (in_last_in),
    .out_valid       (out_valid),
    .out_sorted_value(out_sorted_value),
    .out_last_out    (out_last_out),
    .out_overflow    (out_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sorter.check_word(out_sorted_value, out_last_out, out_overflow);
  end

  // Offer one word after an optional idle gap; hold it until the engine takes it.
  task automatic send_word(input logic signed [DATA_W-1:0] v, input logic last);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_value   <= v;
    in_last_in <= last;
    do @(posedge clk); while (busy);
    sorter.take_word(v, last);
    words_sent++;
  endtask

  task automatic send_list(input int unsigned len);
    logic signed [DATA_W-1:0] v;
    burst = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 3))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7FFF_FFFF;
            2: v = 32'sh0000_0000;
            default: v = 32'shFFFF_FFFF;
          endcase
        end
        // narrow range to get plenty of equal words
        1, 2: v = $signed($urandom_range(0, 14)) - 7;
        default: v = $urandom;
      endcase
      send_word(v, i == len - 1);
    end
  endtask

  // Hold off until every expected sorted word has come out.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sorter.pending() != 0);
  endtask

  initial begin
    sorter     = new();
    rst_n      = 1'b0;
    start      = 1'b0;
    in_value   = '0;
    in_last_in = 1'b0;
    burst      = 1'b0;
    words_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-word lists at both extremes
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b1);
    // two words out of order
    send_word(32'sd3, 1'b0);
    send_word(-32'sd2, 1'b1);
    // extremes, sign boundary and alternating bit patterns
    send_word(32'sd0, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shAAAA_AAAA, 1'b1);
    // equal words
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b1);
    // strictly descending
    send_word(32'sd40, 1'b0);
    send_word(32'sd30, 1'b0);
    send_word(32'sd20, 1'b0);
    send_word(-32'sd10, 1'b0);
    send_word(-32'sd50, 1'b1);
    drain();

    // exactly full, then one over so the flagged last word is dropped
    send_list(CAPACITY);
    send_list(CAPACITY + 1);
    while (words_sent < 360) begin
      case ($urandom_range(0, 19))
        0: send_list(CAPACITY);
        1: send_list($urandom_range(CAPACITY + 1, CAPACITY + 4));
        default: send_list($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sorter.faults == 0 && sorter.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
